// ----- rtl/yaw_pitch_view_transform_unit_assert.svh -----
// Assertion macros used by the view transform top-level module.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef YAW_PITCH_VIEW_TRANSFORM_UNIT_ASSERT_SVH
`define YAW_PITCH_VIEW_TRANSFORM_UNIT_ASSERT_SVH

// Same-cycle implication.
`define YPVT_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define YPVT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/ypvt_pkg.sv -----
package ypvt_pkg;

  // CORDIC datapath: 32-bit-per-turn angles, Q2.30 vectors, two guard bits.
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_W     = 34;
  localparam int TRIG_W       = 16;
  localparam int CFG_IDX_W    = 3;

  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAM_POS_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_ANGLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_ANGLE = 3'd4;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    logic                       fold;
  } cordic_t;

  typedef struct packed {
    cordic_t yaw;
    cordic_t pitch;
  } trig_pair_t;

  // Arctangent of 2^-step in units of 2^32 per turn.
  function automatic logic [CORDIC_W-1:0] atan_turn(input int step);
    logic [CORDIC_W-1:0] a;
    case (step)
      0:       a = 34'h020000000;
      1:       a = 34'h012E4051E;
      2:       a = 34'h009FB385B;
      3:       a = 34'h0051111D4;
      4:       a = 34'h0028B0D43;
      5:       a = 34'h00145D7E1;
      6:       a = 34'h000A2F61E;
      7:       a = 34'h000517C55;
      8:       a = 34'h00028BE53;
      9:       a = 34'h000145F2F;
      10:      a = 34'h0000A2F98;
      11:      a = 34'h0000517CC;
      12:      a = 34'h000028BE6;
      13:      a = 34'h0000145F3;
      14:      a = 34'h00000A2FA;
      15:      a = 34'h00000517D;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/ypvt_cordic_cell.sv -----
module ypvt_cordic_cell #(
  parameter int STEP        = 0,
  parameter int COORD_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        valid_in,
  input  logic signed [COORD_WIDTH:0] dx_in,
  input  logic signed [COORD_WIDTH:0] dy_in,
  input  logic signed [COORD_WIDTH:0] dz_in,
  input  ypvt_pkg::trig_pair_t        trig_in,
  output logic                        valid_out,
  output logic signed [COORD_WIDTH:0] dx_out,
  output logic signed [COORD_WIDTH:0] dy_out,
  output logic signed [COORD_WIDTH:0] dz_out,
  output ypvt_pkg::trig_pair_t        trig_out
);

  localparam logic signed [ypvt_pkg::CORDIC_W-1:0] ATAN =
    $signed(ypvt_pkg::atan_turn(STEP));

  // One micro-rotation: turn toward zero residual angle.
  function automatic ypvt_pkg::cordic_t rotate(input ypvt_pkg::cordic_t c);
    ypvt_pkg::cordic_t          r;
    logic signed [ypvt_pkg::CORDIC_W-1:0] xs;
    logic signed [ypvt_pkg::CORDIC_W-1:0] ys;
    xs = $signed(c.x) >>> STEP;
    ys = $signed(c.y) >>> STEP;
    r.fold = c.fold;
    if (!c.z[ypvt_pkg::CORDIC_W-1]) begin
      r.x = c.x - ys;
      r.y = c.y + xs;
      r.z = c.z - ATAN;
    end else begin
      r.x = c.x + ys;
      r.y = c.y - xs;
      r.z = c.z + ATAN;
    end
    return r;
  endfunction

  logic                 valid_r;
  ypvt_pkg::trig_pair_t trig_r;
  ypvt_pkg::trig_pair_t trig_nxt;
  logic signed [COORD_WIDTH:0] dx_r, dy_r, dz_r;

  always_comb begin
    trig_nxt.yaw   = rotate(trig_in.yaw);
    trig_nxt.pitch = rotate(trig_in.pitch);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trig_r <= trig_nxt;
      dx_r   <= dx_in;
      dy_r   <= dy_in;
      dz_r   <= dz_in;
    end
  end

  assign valid_out = valid_r;
  assign trig_out  = trig_r;
  assign dx_out    = dx_r;
  assign dy_out    = dy_r;
  assign dz_out    = dz_r;

endmodule

// ----- rtl/ypvt_rotate.sv -----
module ypvt_rotate #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_in,
  input  logic signed [COORD_WIDTH:0]   dx_in,
  input  logic signed [COORD_WIDTH:0]   dy_in,
  input  logic signed [COORD_WIDTH:0]   dz_in,
  input  ypvt_pkg::trig_pair_t          trig_in,
  input  logic                          out_ready,
  output logic                          adv,
  output logic                          out_valid,
  output logic [COORD_WIDTH-1:0]        view_x,
  output logic [COORD_WIDTH-1:0]        view_y,
  output logic [COORD_WIDTH-1:0]        view_z,
  output logic                          saturated
);

  localparam int TW = ypvt_pkg::TRIG_W;
  localparam int DW = COORD_WIDTH + 1;
  localparam int P1 = DW + TW;
  localparam int S1 = P1 + 1;
  localparam int R1 = S1 - 15;
  localparam int P2 = R1 + TW;
  localparam int S2 = P2 + 1;
  localparam int R2 = S2 - 15;

  localparam logic signed [S1-1:0] HALF1 = S1'(16384);
  localparam logic signed [S2-1:0] HALF2 = S2'(16384);

  // Q2.30 to Q1.15, round half up, negate when folded, clamp.
  function automatic logic signed [TW-1:0] to_q15(
    input logic signed [ypvt_pkg::CORDIC_W-1:0] v,
    input logic                                 fold
  );
    logic signed [ypvt_pkg::CORDIC_W:0] t;
    logic signed [20:0]                 r;
    t = {v[ypvt_pkg::CORDIC_W-1], v} + 35'sd16384;
    r = {t[ypvt_pkg::CORDIC_W], t[ypvt_pkg::CORDIC_W:15]};
    if (fold) begin
      r = -r;
    end
    if ((&r[20:TW-1]) || !(|r[20:TW-1])) begin
      return r[TW-1:0];
    end
    return {r[20], {(TW-1){~r[20]}}};
  endfunction

  // Trig stage
  logic                        t_valid_r;
  logic signed [TW-1:0]        cy_r, sy_r, cx_r, sx_r;
  logic signed [DW-1:0]        t_dx_r, t_dy_r, t_dz_r;
  // First product stage
  logic                        m1_valid_r;
  logic signed [P1-1:0]        p_dx_cy_r, p_dz_sy_r, p_dx_sy_r, p_dz_cy_r;
  logic signed [DW-1:0]        m1_dy_r;
  logic signed [TW-1:0]        m1_cx_r, m1_sx_r;
  // Yaw sum stage
  logic                        a1_valid_r;
  logic signed [R1-1:0]        x1_r, z1_r;
  logic signed [DW-1:0]        a1_dy_r;
  logic signed [TW-1:0]        a1_cx_r, a1_sx_r;
  // Second product stage
  logic                        m2_valid_r;
  logic signed [P2-1:0]        p_dy_cx_r, p_z1_sx_r, p_dy_sx_r, p_z1_cx_r;
  logic signed [R1-1:0]        m2_x1_r;
  // Output register
  logic                        out_valid_r;
  logic [COORD_WIDTH-1:0]      vx_r, vy_r, vz_r;
  logic                        sat_r;

  logic                        load;
  logic signed [S1-1:0]        x1_sum, z1_sum;
  logic signed [S2-1:0]        y2_sum, z2_sum;
  logic signed [R2-1:0]        y2, z2;
  logic [COORD_WIDTH-1:0]      vx_nxt, vy_nxt, vz_nxt;
  logic                        sx_f, sy_f, sz_f;

  assign load = !out_valid_r || out_ready;
  assign adv  = load || !m2_valid_r;

  assign x1_sum = p_dx_cy_r + p_dz_sy_r + HALF1;
  assign z1_sum = p_dz_cy_r - p_dx_sy_r + HALF1;
  assign y2_sum = p_dy_cx_r - p_z1_sx_r + HALF2;
  assign z2_sum = p_dy_sx_r + p_z1_cx_r + HALF2;
  assign y2     = y2_sum[S2-1:15];
  assign z2     = z2_sum[S2-1:15];

  always_comb begin
    sx_f = !((&m2_x1_r[R1-1:COORD_WIDTH-1]) || !(|m2_x1_r[R1-1:COORD_WIDTH-1]));
    sy_f = !((&y2[R2-1:COORD_WIDTH-1]) || !(|y2[R2-1:COORD_WIDTH-1]));
    sz_f = !((&z2[R2-1:COORD_WIDTH-1]) || !(|z2[R2-1:COORD_WIDTH-1]));
    vx_nxt = sx_f ? {m2_x1_r[R1-1], {(COORD_WIDTH-1){~m2_x1_r[R1-1]}}}
                  : m2_x1_r[COORD_WIDTH-1:0];
    vy_nxt = sy_f ? {y2[R2-1], {(COORD_WIDTH-1){~y2[R2-1]}}} : y2[COORD_WIDTH-1:0];
    vz_nxt = sz_f ? {z2[R2-1], {(COORD_WIDTH-1){~z2[R2-1]}}} : z2[COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_valid_r   <= 1'b0;
      m1_valid_r  <= 1'b0;
      a1_valid_r  <= 1'b0;
      m2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        t_valid_r  <= valid_in;
        m1_valid_r <= t_valid_r;
        a1_valid_r <= m1_valid_r;
        m2_valid_r <= a1_valid_r;
      end
      if (load) begin
        out_valid_r <= m2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cy_r      <= to_q15(trig_in.yaw.x, trig_in.yaw.fold);
      sy_r      <= to_q15(trig_in.yaw.y, trig_in.yaw.fold);
      cx_r      <= to_q15(trig_in.pitch.x, trig_in.pitch.fold);
      sx_r      <= to_q15(trig_in.pitch.y, trig_in.pitch.fold);
      t_dx_r    <= dx_in;
      t_dy_r    <= dy_in;
      t_dz_r    <= dz_in;

      p_dx_cy_r <= t_dx_r * cy_r;
      p_dz_sy_r <= t_dz_r * sy_r;
      p_dx_sy_r <= t_dx_r * sy_r;
      p_dz_cy_r <= t_dz_r * cy_r;
      m1_dy_r   <= t_dy_r;
      m1_cx_r   <= cx_r;
      m1_sx_r   <= sx_r;

      x1_r      <= x1_sum[S1-1:15];
      z1_r      <= z1_sum[S1-1:15];
      a1_dy_r   <= m1_dy_r;
      a1_cx_r   <= m1_cx_r;
      a1_sx_r   <= m1_sx_r;

      p_dy_cx_r <= a1_dy_r * a1_cx_r;
      p_z1_sx_r <= z1_r * a1_sx_r;
      p_dy_sx_r <= a1_dy_r * a1_sx_r;
      p_z1_cx_r <= z1_r * a1_cx_r;
      m2_x1_r   <= x1_r;
    end
    if (load) begin
      vx_r  <= vx_nxt;
      vy_r  <= vy_nxt;
      vz_r  <= vz_nxt;
      sat_r <= sx_f || sy_f || sz_f;
    end
  end

  assign out_valid = out_valid_r;
  assign view_x    = vx_r;
  assign view_y    = vy_r;
  assign view_z    = vz_r;
  assign saturated = sat_r;

endmodule

// ----- rtl/yaw_pitch_view_transform_unit.sv -----
// Yaw/pitch view transform. Each input transaction carries one world-space
// vertex (signed Q16.16 x, y, z); each output transaction carries the same
// vertex in camera space, saturated to the coordinate width, plus a flag that
// is set when any component was clipped. The camera position is subtracted,
// the offset is rotated about the vertical axis by the yaw angle and then
// about the horizontal axis by the pitch angle. With the output side ready,
// the block takes one vertex per clock and delivers one result per clock. A
// vertex passes through 22 register stages: the entry stage, which forms the
// camera offsets and folds the angles into a quarter turn, the chain of 16
// CORDIC cells that turns the angles into sine and cosine next to the vertex,
// a rounding stage, the yaw products, the yaw sums, the pitch products, and
// the output register, which also forms the pitch sums and saturates. Each
// vertex carries its own copy of the angles through the cell chain, so a
// vertex may follow a configuration write in the next cycle. The pipeline
// stalls only when the output register is held and the last internal stage
// is occupied. While the output is held, an empty last internal stage is
// filled from above, but bubbles further up the pipeline move along with the
// data and are not squeezed out.
`include "yaw_pitch_view_transform_unit_assert.svh"

module yaw_pitch_view_transform_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,

  // Input stream. tdata: vertex_x, vertex_y, vertex_z (lowest bits first).
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,

  // Output stream. tdata: view_x, view_y, view_z (lowest bits first).
  // tuser: saturated.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     out_tdata,
  output logic [0:0]                             out_tuser,

  // Register writes.
  input  logic                                   cfg_wr_en,
  input  logic [ypvt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [((COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH)-1:0] cfg_wdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int STEPS = ypvt_pkg::CORDIC_STEPS;
  localparam int OUT_W = ((3*COORD_WIDTH+7)/8)*8;

  localparam logic [CW-1:0] POS_LIM = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] NEG_LIM = {1'b1, {(CW-1){1'b0}}};

  // Widen an angle to 32 bits per turn, fold it into [-1/4, 1/4) turn, and
  // build the CORDIC start vector.
  function automatic ypvt_pkg::cordic_t cordic_init(input logic [ANGLE_WIDTH-1:0] ang);
    ypvt_pkg::cordic_t c;
    logic [31:0]       a;
    logic              fold;
    a      = {ang, {(32-ANGLE_WIDTH){1'b0}}};
    fold   = a[31] ^ a[30];
    c.x    = ypvt_pkg::CORDIC_START;
    c.y    = '0;
    c.z    = {{2{a[31] ^ fold}}, a[31] ^ fold, a[30:0]};
    c.fold = fold;
    return c;
  endfunction

  // Configuration registers.
  logic signed [CW-1:0]   cam_x_r, cam_y_r, cam_z_r;
  logic [ANGLE_WIDTH-1:0] yaw_r, pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      yaw_r   <= '0;
      pitch_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ypvt_pkg::REG_CAM_POS_X:   cam_x_r <= cfg_wdata[CW-1:0];
        ypvt_pkg::REG_CAM_POS_Y:   cam_y_r <= cfg_wdata[CW-1:0];
        ypvt_pkg::REG_CAM_POS_Z:   cam_z_r <= cfg_wdata[CW-1:0];
        ypvt_pkg::REG_YAW_ANGLE:   yaw_r   <= cfg_wdata[ANGLE_WIDTH-1:0];
        ypvt_pkg::REG_PITCH_ANGLE: pitch_r <= cfg_wdata[ANGLE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Taps between the entry stage (tap 0) and the cells of the chain.
  logic [STEPS:0]       chain_valid;
  logic signed [CW:0]   chain_dx [STEPS+1];
  logic signed [CW:0]   chain_dy [STEPS+1];
  logic signed [CW:0]   chain_dz [STEPS+1];
  ypvt_pkg::trig_pair_t chain_trig [STEPS+1];

  logic                 adv;
  logic                 ent_valid_r;
  logic signed [CW:0]   ent_dx_r, ent_dy_r, ent_dz_r;
  ypvt_pkg::trig_pair_t ent_trig_r;
  logic [CW-1:0]        vin_x, vin_y, vin_z;

  logic                 res_valid;
  logic [CW-1:0]        view_x, view_y, view_z;
  logic                 res_sat;

  assign in_tready = adv;
  assign vin_x     = in_tdata[CW-1:0];
  assign vin_y     = in_tdata[2*CW-1:CW];
  assign vin_z     = in_tdata[3*CW-1:2*CW];

  // Entry stage: camera offsets are exact, one bit wider than a coordinate.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
    end else if (adv) begin
      ent_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_dx_r         <= {vin_x[CW-1], vin_x} - {cam_x_r[CW-1], cam_x_r};
      ent_dy_r         <= {vin_y[CW-1], vin_y} - {cam_y_r[CW-1], cam_y_r};
      ent_dz_r         <= {vin_z[CW-1], vin_z} - {cam_z_r[CW-1], cam_z_r};
      ent_trig_r.yaw   <= cordic_init(yaw_r);
      ent_trig_r.pitch <= cordic_init(pitch_r);
    end
  end

  assign chain_valid[0] = ent_valid_r;
  assign chain_dx[0]    = ent_dx_r;
  assign chain_dy[0]    = ent_dy_r;
  assign chain_dz[0]    = ent_dz_r;
  assign chain_trig[0]  = ent_trig_r;

  // CORDIC cell chain: cell k applies the 2^-k micro-rotation to both angles.
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    ypvt_cordic_cell #(
      .STEP        (k),
      .COORD_WIDTH (CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .valid_in  (chain_valid[k]),
      .dx_in     (chain_dx[k]),
      .dy_in     (chain_dy[k]),
      .dz_in     (chain_dz[k]),
      .trig_in   (chain_trig[k]),
      .valid_out (chain_valid[k+1]),
      .dx_out    (chain_dx[k+1]),
      .dy_out    (chain_dy[k+1]),
      .dz_out    (chain_dz[k+1]),
      .trig_out  (chain_trig[k+1])
    );
  end

  // Rounding, two rotations, saturation and the output register.
  ypvt_rotate #(
    .COORD_WIDTH (CW)
  ) u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (chain_valid[STEPS]),
    .dx_in     (chain_dx[STEPS]),
    .dy_in     (chain_dy[STEPS]),
    .dz_in     (chain_dz[STEPS]),
    .trig_in   (chain_trig[STEPS]),
    .out_ready (out_tready),
    .adv       (adv),
    .out_valid (res_valid),
    .view_x    (view_x),
    .view_y    (view_y),
    .view_z    (view_z),
    .saturated (res_sat)
  );

  assign out_tvalid   = res_valid;
  assign out_tdata    = OUT_W'({view_z, view_y, view_x});
  assign out_tuser[0] = res_sat;

  // An accepted transaction always lands in the entry stage.
  `YPVT_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, chain_valid[0],
                    "accepted vertex lost at entry")
  // Input is refused only while a finished result is held at the output.
  `YPVT_ASSERT_IMPL(a_stall_cause, !in_tready, out_tvalid && !out_tready,
                    "pipeline stalled without output backpressure")
  // A stalled chain keeps every occupied slot.
  `YPVT_ASSERT_NEXT(a_chain_holds, !adv, $stable(chain_valid), "cell chain moved during a stall")
  // The clip flag only comes with a component at a range limit.
  `YPVT_ASSERT_IMPL(a_sat_limit, out_tvalid && out_tuser[0],
                    view_x == POS_LIM || view_x == NEG_LIM || view_y == POS_LIM ||
                    view_y == NEG_LIM || view_z == POS_LIM || view_z == NEG_LIM,
                    "saturated flag without a clipped component")

endmodule

// ----- dv/yaw_pitch_view_transform_unit_tb.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the yaw/pitch view transform. For every accepted
// vertex the expected camera-space vertex is queued, taken from a behavioral
// camera model kept in this file or, for ROW_KNOWN rows, from the row itself.
// Every output transaction is compared, field by field, with the oldest
// queued vertex. Register writes happen only while the pipeline is empty.
module yaw_pitch_view_transform_unit_tb;

  localparam int CW = 32;
  localparam int AW = 16;
  localparam int CFG_W = (CW > AW) ? CW : AW;
  localparam int IDX_W = ypvt_pkg::CFG_IDX_W;
  localparam int TDATA_W = ((3 * CW + 7) / 8) * 8;

  // The CORDIC works on angles of 2^32 units per turn. Its start vector is
  // 1.0 in Q2.30, already divided by the gain of the sixteen rotations.
  localparam int ROTATION_STEPS = 16;
  localparam longint UNIT_VECTOR = 64'sd652032874;
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam longint QUARTER_TURN = 64'sd1073741824;

  // Register indexes that decode to nothing. Writes to them must be dropped.
  localparam logic [IDX_W-1:0] REG_SPARE_LO  = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPARE_MID = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI  = 3'd7;

  // A pipeline of this depth never goes this long without moving a vertex.
  localparam int STALL_LIMIT = 2000;
  // Cycles to watch for stray results once everything has arrived.
  localparam int SETTLE_CYCLES = 50;

  localparam int PHASES = 4;
  localparam int SETS_PER_PHASE = 3;
  localparam int VERTICES_PER_SET = 100;

  // The first field sits in the lowest bits of in_tdata, so x is listed last.
  typedef struct packed {
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } vertex_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 clipped;
  } view_t;

  typedef enum logic [1:0] {ROW_VERTEX, ROW_KNOWN, ROW_WRITE} row_kind_t;

  // One row of the directed part. A register write uses idx and wdata; a
  // vertex uses vx, vy and vz. Rows of kind ROW_KNOWN carry their answer.
  typedef struct packed {
    row_kind_t            kind;
    logic [IDX_W-1:0]     idx;
    logic [CFG_W-1:0]     wdata;
    logic [CW-1:0]        vx;
    logic [CW-1:0]        vy;
    logic [CW-1:0]        vz;
    logic [CW-1:0]        ex;
    logic [CW-1:0]        ey;
    logic [CW-1:0]        ez;
    logic                 eclip;
  } plan_row_t;

  localparam int PLAN_LEN = 28;

  // Directed part. A vertex equal to the camera position has a zero offset,
  // so its answer is zero whatever the angles are. Some angle writes carry junk
  // in the bits above the angle width, which the block has to drop.
  plan_row_t directed_plan [PLAN_LEN] = '{
    // Right after reset: origin, the coordinate extremes, then small values.
    '{ROW_KNOWN,  '0, '0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, '0, '0, '0, 1'b0},
    '{ROW_VERTEX, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0, 1'b0},
    '{ROW_VERTEX, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0, 1'b0},
    '{ROW_VERTEX, '0, '0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, '0, '0, '0, 1'b0},
    // Yaw exactly a quarter turn (folds), pitch just below minus a quarter.
    '{ROW_WRITE, ypvt_pkg::REG_YAW_ANGLE,   32'hABCD_4000, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_WRITE, ypvt_pkg::REG_PITCH_ANGLE, 32'h1234_BFFF, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_VERTEX, '0, '0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, '0, '0, '0, 1'b0},
    '{ROW_VERTEX, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0, 1'b0},
    // Yaw exactly minus a quarter turn (no fold), pitch a half turn.
    '{ROW_WRITE, ypvt_pkg::REG_YAW_ANGLE,   32'h0000_C000, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_WRITE, ypvt_pkg::REG_PITCH_ANGLE, 32'h0000_8000, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_VERTEX, '0, '0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, '0, '0, '0, 1'b0},
    // Largest yaw code, pitch just short of a quarter turn.
    '{ROW_WRITE, ypvt_pkg::REG_YAW_ANGLE,   32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_WRITE, ypvt_pkg::REG_PITCH_ANGLE, 32'h0000_3FFF, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_VERTEX, '0, '0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C, '0, '0, '0, 1'b0},
    // Camera at the corners of the coordinate range.
    '{ROW_WRITE, ypvt_pkg::REG_CAM_POS_X,   32'h8000_0000, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_WRITE, ypvt_pkg::REG_CAM_POS_Y,   32'h7FFF_FFFF, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_WRITE, ypvt_pkg::REG_CAM_POS_Z,   32'h8000_0000, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_KNOWN,  '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0, 1'b0},
    '{ROW_VERTEX, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0, '0, 1'b0},
    // Writes to undecoded indexes must leave every register alone.
    '{ROW_WRITE, REG_SPARE_LO,    32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_WRITE, REG_SPARE_MID,   32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_WRITE, REG_SPARE_HI,    32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_KNOWN,  '0, '0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0, 1'b0},
    '{ROW_VERTEX, '0, '0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, '0, '0, '0, 1'b0},
    // Both angles right at and right below the quarter-turn fold.
    '{ROW_WRITE, ypvt_pkg::REG_PITCH_ANGLE, 32'h0000_4000, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_WRITE, ypvt_pkg::REG_YAW_ANGLE,   32'h0000_3FFF, '0, '0, '0, '0, '0, '0, 1'b0},
    '{ROW_VERTEX, '0, '0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, '0, '0, '0, 1'b0},
    '{ROW_VERTEX, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0, 1'b0}
  };

  logic clk;
  logic rst_n = 1'b0;

  logic               in_tvalid = 1'b0;
  logic               in_tready;
  // Fields from bit 0 up: vertex_x, vertex_y, vertex_z.
  logic [TDATA_W-1:0] in_tdata = '0;

  logic               out_tvalid;
  logic               out_tready = 1'b0;
  // Fields from bit 0 up: view_x, view_y, view_z.
  logic [TDATA_W-1:0] out_tdata;
  // Fields from bit 0 up: saturated.
  logic [0:0]         out_tuser;

  logic                 cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Mirror of the block's registers, updated on every write the bench makes.
  logic signed [CW-1:0] cam_x = '0;
  logic signed [CW-1:0] cam_y = '0;
  logic signed [CW-1:0] cam_z = '0;
  logic [AW-1:0]        yaw = '0;
  logic [AW-1:0]        pitch = '0;

  // Camera-space vertices still owed by the block, oldest first.
  view_t pending_views[$];

  int failures = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  yaw_pitch_view_transform_unit #(
    .COORD_WIDTH(CW),
    .ANGLE_WIDTH(AW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Arctangent of 2^-i, in 2^32 units per turn.
  function automatic longint arctan_step(input int i);
    case (i)
      0:  return 64'h2000_0000;
      1:  return 64'h12E4_051E;
      2:  return 64'h09FB_385B;
      3:  return 64'h0511_11D4;
      4:  return 64'h028B_0D43;
      5:  return 64'h0145_D7E1;
      6:  return 64'h00A2_F61E;
      7:  return 64'h0051_7C55;
      8:  return 64'h0028_BE53;
      9:  return 64'h0014_5F2F;
      10: return 64'h000A_2F98;
      11: return 64'h0005_17CC;
      12: return 64'h0002_8BE6;
      13: return 64'h0001_45F3;
      14: return 64'h0000_A2FA;
      default: return 64'h0000_517D;
    endcase
  endfunction

  // Rounds a Q2.30 CORDIC output to Q1.15, negates it when the angle was
  // folded, and clamps it to the Q1.15 range.
  function automatic longint trig_to_q15(input longint v, input bit negate);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (negate) r = -r;
    if (r > 64'sd32767) r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return r;
  endfunction

  // Sine and cosine of an angle code, both Q1.15.
  function automatic void angle_sin_cos(input logic [AW-1:0] ang,
                                        output longint s, output longint c);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit folded;
    z = longint'(ang) << (32 - AW);
    if (z >= HALF_TURN) z -= 2 * HALF_TURN;
    // Only angles within a quarter turn of zero go through the rotations;
    // the rest are turned by half a turn and the results negated.
    folded = 1'b0;
    if (z >= QUARTER_TURN) begin
      z -= HALF_TURN;
      folded = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z += HALF_TURN;
      folded = 1'b1;
    end
    x = UNIT_VECTOR;
    y = 0;
    for (int i = 0; i < ROTATION_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_step(i);
      end
      x = nx;
    end
    c = trig_to_q15(x, folded);
    s = trig_to_q15(y, folded);
  endfunction

  // An exact sum of products with Q1.15 factors, rounded half up to Q16.16.
  function automatic longint round_sum(input longint sum);
    return (sum + 64'sd16384) >>> 15;
  endfunction

  function automatic logic signed [CW-1:0] clip_coord(input longint v, inout bit clipped);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v = hi;
      clipped = 1'b1;
    end
    if (v < lo) begin
      v = lo;
      clipped = 1'b1;
    end
    return v[CW-1:0];
  endfunction

  // Camera-space vertex for a world-space vertex under the current registers.
  function automatic view_t predict_view(input vertex_t v);
    longint dx, dy, dz;
    longint sin_yaw, cos_yaw, sin_pitch, cos_pitch;
    longint x1, z1, y2, z2;
    bit clipped;
    view_t r;
    dx = longint'(v.x) - longint'(cam_x);
    dy = longint'(v.y) - longint'(cam_y);
    dz = longint'(v.z) - longint'(cam_z);
    angle_sin_cos(yaw, sin_yaw, cos_yaw);
    angle_sin_cos(pitch, sin_pitch, cos_pitch);
    x1 = round_sum(dx * cos_yaw + dz * sin_yaw);
    // z1 stays wide; only the final outputs are clipped.
    z1 = round_sum(dz * cos_yaw - dx * sin_yaw);
    y2 = round_sum(dy * cos_pitch - z1 * sin_pitch);
    z2 = round_sum(dy * sin_pitch + z1 * cos_pitch);
    clipped = 1'b0;
    r.x = clip_coord(x1, clipped);
    r.y = clip_coord(y2, clipped);
    r.z = clip_coord(z2, clipped);
    r.clipped = clipped;
    return r;
  endfunction

  // Coordinates of widely varying magnitude, with the extremes now and then.
  function automatic logic signed [CW-1:0] random_coord();
    logic signed [CW-1:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: r = {1'b0, {(CW-1){1'b1}}};
          1: r = {1'b1, {(CW-1){1'b0}}};
          2: r = '0;
          3: r = '1;
          default: r = 1;
        endcase
      end
      1, 2: ;
      default: r = r >>> $urandom_range(20);
    endcase
    return r;
  endfunction

  // An angle write with random upper bits; the angle often sits at a fold.
  function automatic logic [CFG_W-1:0] random_angle();
    logic [CFG_W-1:0] r;
    int quarter;
    r = $urandom;
    quarter = 1 << (AW - 2);
    case ($urandom_range(9))
      0: r[AW-1:0] = AW'(quarter);
      1: r[AW-1:0] = AW'(quarter - 1);
      2: r[AW-1:0] = AW'(3 * quarter);
      3: r[AW-1:0] = AW'(3 * quarter - 1);
      4: r[AW-1:0] = AW'(2 * quarter);
      5: r[AW-1:0] = '0;
      6: r[AW-1:0] = '1;
      default: ;
    endcase
    return r;
  endfunction

  // Drives one register write and leaves cfg_wr_en high, so that writes can
  // follow back to back; the caller lowers it after the last one.
  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      ypvt_pkg::REG_CAM_POS_X:   cam_x = data[CW-1:0];
      ypvt_pkg::REG_CAM_POS_Y:   cam_y = data[CW-1:0];
      ypvt_pkg::REG_CAM_POS_Z:   cam_z = data[CW-1:0];
      ypvt_pkg::REG_YAW_ANGLE:   yaw = data[AW-1:0];
      ypvt_pkg::REG_PITCH_ANGLE: pitch = data[AW-1:0];
      default: ;
    endcase
  endtask

  // Offers one vertex, with random idle cycles ahead of it, and queues its
  // answer once the transaction has been accepted.
  task automatic send_vertex(input vertex_t v, input view_t answer);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    pending_views.push_back(answer);
  endtask

  // Holds the input side off until every queued answer has come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  task automatic configure_random();
    write_reg(ypvt_pkg::REG_CAM_POS_X, random_coord());
    write_reg(ypvt_pkg::REG_CAM_POS_Y, random_coord());
    write_reg(ypvt_pkg::REG_CAM_POS_Z, random_coord());
    write_reg(ypvt_pkg::REG_YAW_ANGLE, random_angle());
    write_reg(ypvt_pkg::REG_PITCH_ANGLE, random_angle());
    if ($urandom_range(3) == 0)
      write_reg(REG_SPARE_LO + IDX_W'($urandom_range(2)), $urandom);
    cfg_wr_en <= 1'b0;
  endtask

  // Output side: random back-pressure, result checking and the watchdog.
  always @(posedge clk) begin
    view_t got;
    view_t want;
    out_tready <= ($urandom_range(99) >= receiver_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got.x = out_tdata[CW-1:0];
      got.y = out_tdata[2*CW-1:CW];
      got.z = out_tdata[3*CW-1:2*CW];
      got.clipped = out_tuser[0];
      if (pending_views.size() == 0) begin
        $error("output transaction with no vertex outstanding: x=%0d y=%0d z=%0d",
               got.x, got.y, got.z);
        failures++;
      end else begin
        want = pending_views.pop_front();
        if (got.x !== want.x) begin
          $error("view_x: expected %0d, got %0d", want.x, got.x);
          failures++;
        end
        if (got.y !== want.y) begin
          $error("view_y: expected %0d, got %0d", want.y, got.y);
          failures++;
        end
        if (got.z !== want.z) begin
          $error("view_z: expected %0d, got %0d", want.z, got.z);
          failures++;
        end
        if (got.clipped !== want.clipped) begin
          $error("saturated: expected %0b, got %0b", want.clipped, got.clipped);
          failures++;
        end
      end
    end
    // Any transaction on either side counts as progress.
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transaction for %0d cycles, %0d vertices outstanding",
             STALL_LIMIT, pending_views.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    plan_row_t row;
    vertex_t v;
    view_t answer;
    bit writing;
    int src_idle_by_phase [PHASES];
    int sink_stall_by_phase [PHASES];

    // Idle mix per random phase: none, sender idle, receiver stalling, both.
    src_idle_by_phase = '{0, 77, 0, 26};
    sink_stall_by_phase = '{0, 0, 77, 26};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: writes are grouped, and each group waits for the
    // pipeline to drain before its first write.
    writing = 1'b0;
    for (int k = 0; k < PLAN_LEN; k++) begin
      row = directed_plan[k];
      if (row.kind == ROW_WRITE) begin
        if (!writing) begin
          wait_for_results();
          writing = 1'b1;
        end
        write_reg(row.idx, row.wdata);
      end else begin
        if (writing) begin
          cfg_wr_en <= 1'b0;
          writing = 1'b0;
        end
        v.x = row.vx;
        v.y = row.vy;
        v.z = row.vz;
        if (row.kind == ROW_KNOWN) begin
          answer.x = row.ex;
          answer.y = row.ey;
          answer.z = row.ez;
          answer.clipped = row.eclip;
        end else begin
          answer = predict_view(v);
        end
        send_vertex(v, answer);
      end
    end

    // Random part: each phase has its own idle mix and several register
    // settings, each applied to an empty pipeline.
    for (int ph = 0; ph < PHASES; ph++) begin
      sender_idle_pct = src_idle_by_phase[ph];
      receiver_stall_pct = sink_stall_by_phase[ph];
      for (int s = 0; s < SETS_PER_PHASE; s++) begin
        wait_for_results();
        configure_random();
        for (int n = 0; n < VERTICES_PER_SET; n++) begin
          // One pause in mid-stream so the pipeline empties and refills.
          if (ph == 2 && s == 1 && n == VERTICES_PER_SET / 2)
            wait_for_results();
          v.x = random_coord();
          v.y = random_coord();
          v.z = random_coord();
          send_vertex(v, predict_view(v));
        end
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
